>>> rtl/qps_pkg.sv
// Shared types, codes and helper functions for the process scheduler.
package qps_pkg;

	typedef struct packed {
		logic [7:0]         id;
		logic [11:0]        service;
		logic [11:0]        elapsed;
		logic [11:0]        count;
		logic signed [15:0] prio;
	} qps_entry_t;

	localparam logic [1:0] ST_RAN    = 2'd0;
	localparam logic [1:0] ST_LOADED = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	localparam logic MODE_RR   = 1'b0;
	localparam logic MODE_PRIO = 1'b1;

	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_QUANTUM = 2'd1;
	localparam logic [1:0] REG_BASE    = 2'd2;

	localparam logic [7:0]  QUANTUM_RST = 8'd2;
	localparam logic [11:0] BASE_RST    = 12'd50;

	localparam int OUT_W = 72;

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		logic signed [15:0] r;
		if (v > 17'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -17'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic [OUT_W-1:0] pack_out(
		input logic [7:0]         ran_id,
		input logic [11:0]        elapsed,
		input logic [11:0]        remaining,
		input logic [11:0]        run_count,
		input logic signed [15:0] new_priority,
		input logic               finished,
		input logic [4:0]         queue_len
	);
		logic [OUT_W-1:0] r;
		r = '0;
		r[7:0]   = ran_id;
		r[19:8]  = elapsed;
		r[31:20] = remaining;
		r[43:32] = run_count;
		r[59:44] = new_priority;
		r[60]    = finished;
		r[65:61] = queue_len;
		return r;
	endfunction

endpackage

>>> rtl/quantum_process_scheduler_core.sv
// Process scheduler: ready queue held in a position-ordered entry memory.
//
// Input stream (s_*): s_tuser is the item kind (load or run), s_tdata carries the
// process id and service time. Output stream (m_*): one transaction per input item,
// m_tuser is the status code, m_tdata the run entry's values and the queue length.
// Configuration is written over the APB port (policy mode, quantum, priority base).
//
// The queue lives in one synchronous memory indexed by queue position. A load
// appends at the tail; its result goes through a pending register. A run on
// a queue of N entries sweeps the memory twice through its single read port, once
// to pick the entry (head or highest priority) and once to age and close up the
// queue, then writes the run entry back at the tail unless it has finished.
// A run on an empty queue, or a load into a full table, reports its status without touching the memory.
// One item is in work at a time; s_tready is high while the block is idle.
//
// Results sit in an output register; a new item is accepted while it waits.
// If the receiver stalls, a finished second result waits internally until the
// output register is free. Reset empties the queue and loads the register
// defaults; no memory clearing pass is needed.
module quantum_process_scheduler_core
	import qps_pkg::*;
#(
	parameter int MAX_PROCS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// APB configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,  // proc_id[7:0], svc_time[19:8]
	input  logic              s_tuser,  // kind
	// output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	// ran_id[7:0], elapsed[19:8], remaining[31:20], run_count[43:32],
	// new_priority[59:44], finished[60], queue_len[65:61]
	output logic [OUT_W-1:0]  m_tdata,
	output logic [1:0]        m_tuser   // status
);

	localparam int LW = $clog2(MAX_PROCS + 1);
	localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FIN,
		S_OUT
	} state_t;

	state_t state_q;

	logic              mode_q;
	logic [7:0]        quantum_q;
	logic [11:0]       base_q;
	logic [LW-1:0]     len_q;
	logic [LW-1:0]     iss_q;
	logic [IW-1:0]     pos_q;
	qps_entry_t        best_q;
	logic [OUT_W-1:0]  pend_data_q;
	logic [1:0]        pend_user_q;

	qps_entry_t        mem [MAX_PROCS];
	qps_entry_t        rd_data_s1;
	logic              rd_vld_s1;
	logic [IW-1:0]     rd_idx_s1;

	logic              rd_en;
	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	qps_entry_t        mem_wdata;

	logic              cfg_wr;
	logic              in_acc;
	logic [7:0]        in_id;
	logic [11:0]       in_svc;
	logic              full;
	logic [IW-1:0]     idx_last;
	logic              rd_last;
	logic [31:0]       len32;
	logic [31:0]       len_dec32;
	logic [31:0]       len_inc32;

	qps_entry_t        new_ent;
	qps_entry_t        aged_ent;
	qps_entry_t        run_ent;
	logic [12:0]       el_sum;
	logic              run_fin;
	logic [11:0]       run_rem;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[3:2])
			REG_MODE:    prdata = {31'b0, mode_q};
			REG_QUANTUM: prdata = {24'b0, quantum_q};
			REG_BASE:    prdata = {20'b0, base_q};
			default:     prdata = '0;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_id    = s_tdata[7:0];
	assign in_svc   = s_tdata[19:8];

	assign full      = (len_q == LW'(MAX_PROCS));
	assign idx_last  = IW'(len_q - LW'(1));
	assign rd_en     = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (iss_q < len_q);
	assign rd_last   = rd_vld_s1 && (rd_idx_s1 == idx_last);
	assign len32     = 32'(len_q);
	assign len_dec32 = 32'(len_q - LW'(1));
	assign len_inc32 = 32'(len_q + LW'(1));

	// new entry for a load
	always_comb begin
		new_ent.id      = in_id;
		new_ent.service = in_svc;
		new_ent.elapsed = '0;
		new_ent.count   = '0;
		new_ent.prio    = sat16($signed({5'b0, base_q}) - $signed({5'b0, in_svc}));
	end

	// waiting entries gain a quantum in priority mode
	always_comb begin
		aged_ent = rd_data_s1;
		if (mode_q == MODE_PRIO) begin
			aged_ent.prio = sat16($signed({rd_data_s1.prio[15], rd_data_s1.prio})
				+ $signed({9'b0, quantum_q}));
		end
	end

	// run entry after its quantum
	always_comb begin
		el_sum  = {1'b0, best_q.elapsed} + {5'b0, quantum_q};
		run_fin = (el_sum >= {1'b0, best_q.service});
		run_ent = best_q;
		run_ent.elapsed = run_fin ? best_q.service : el_sum[11:0];
		run_ent.count   = (best_q.count == 12'hfff) ? best_q.count : best_q.count + 12'd1;
		run_ent.prio    = run_fin ? 16'sd0
			: sat16($signed({best_q.prio[15], best_q.prio}) - $signed({9'b0, quantum_q}));
		run_rem = best_q.service - run_ent.elapsed;
	end

	// memory write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = new_ent;
		case (state_q)
			S_IDLE: begin
				if (in_acc && s_tuser == KIND_LOAD && !full) begin
					mem_we    = 1'b1;
					mem_waddr = len_q[IW-1:0];
				end
			end
			S_SHIFT: begin
				mem_wdata = aged_ent;
				if (rd_vld_s1 && rd_idx_s1 < pos_q) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1;
				end else if (rd_vld_s1 && rd_idx_s1 > pos_q) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1 - IW'(1);
				end
			end
			S_FIN: begin
				mem_wdata = run_ent;
				if (!run_fin) begin
					mem_we    = 1'b1;
					mem_waddr = idx_last;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[iss_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_RR;
			quantum_q   <= QUANTUM_RST;
			base_q      <= BASE_RST;
			len_q       <= '0;
			iss_q       <= '0;
			pos_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			best_q      <= '0;
			pend_data_q <= '0;
			pend_user_q <= ST_RAN;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
			m_tuser     <= ST_RAN;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_MODE:    mode_q    <= pwdata[0];
					REG_QUANTUM: quantum_q <= pwdata[7:0];
					REG_BASE:    base_q    <= pwdata[11:0];
					default:     ;
				endcase
			end

			rd_vld_s1 <= rd_en;
			rd_idx_s1 <= iss_q[IW-1:0];
			if (rd_en) begin
				iss_q <= iss_q + LW'(1);
			end

			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						iss_q       <= '0;
						pend_data_q <= pack_out('0, '0, '0, '0, '0, 1'b0, len32[4:0]);
						state_q     <= S_OUT;
						if (s_tuser == KIND_LOAD) begin
							if (full) begin
								pend_user_q <= ST_FULL;
							end else begin
								len_q       <= len_q + LW'(1);
								pend_user_q <= ST_LOADED;
								pend_data_q <= pack_out('0, '0, '0, '0, '0, 1'b0,
									len_inc32[4:0]);
							end
						end else if (len_q == '0) begin
							pend_user_q <= ST_EMPTY;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_vld_s1) begin
						if (rd_idx_s1 == '0 ||
							(mode_q == MODE_PRIO && rd_data_s1.prio > best_q.prio)) begin
							best_q <= rd_data_s1;
							pos_q  <= rd_idx_s1;
						end
					end
					if (rd_last) begin
						iss_q   <= '0;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (rd_last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					pend_user_q <= ST_RAN;
					if (run_fin) begin
						len_q       <= len_q - LW'(1);
						pend_data_q <= pack_out(run_ent.id, run_ent.elapsed, run_rem,
							run_ent.count, run_ent.prio, 1'b1, len_dec32[4:0]);
					end else begin
						pend_data_q <= pack_out(run_ent.id, run_ent.elapsed, run_rem,
							run_ent.count, run_ent.prio, 1'b0, len32[4:0]);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= pend_data_q;
						m_tuser  <= pend_user_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_PROCS))
		else $error("queue length above table size");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_SHIFT) |-> len_q != '0)
		else $error("sweep over an empty queue");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("accepted transaction not taken into work");

	a_fin_len_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !run_fin) |=> $stable(len_q))
		else $error("queue length changed for an unfinished run");

endmodule
